// ===== rtl/rdv_pkg.sv =====
package rdv_pkg;

  localparam int SLOT_COUNT = 24;
  localparam int HART_COUNT = 32;

  // address bits for the slot store, at least one
  localparam int SLOT_AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam logic [1:0] OP_WAIT       = 2'd0;
  localparam logic [1:0] OP_NOTIFY     = 2'd1;
  localparam logic [1:0] OP_NOTIFY_OWN = 2'd2;

  localparam logic [1:0] OUT_PARKED   = 2'd0;
  localparam logic [1:0] OUT_RELEASED = 2'd1;
  localparam logic [1:0] OUT_ERROR    = 2'd2;

  typedef enum logic [1:0] {
    ROLE_EMPTY    = 2'd0,
    ROLE_WAITER   = 2'd1,
    ROLE_NOTIFIER = 2'd2
  } rdv_role_t;

  typedef struct packed {
    rdv_role_t  role;
    logic [4:0] hart;
  } rdv_entry_t;

  typedef struct packed {
    logic               en;
    logic [SLOT_AW-1:0] addr;
    rdv_entry_t         data;
  } rdv_wr_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } rdv_state_t;

endpackage

// ===== rtl/rdv_slot_ram.sv =====
module rdv_slot_ram (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_en,
  input  logic [rdv_pkg::SLOT_AW-1:0] rd_addr,
  output rdv_pkg::rdv_entry_t        rd_data,
  input  rdv_pkg::rdv_wr_t           wr
);
  import rdv_pkg::*;

  rdv_entry_t              mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]   vld;
  rdv_entry_t              rd_q;
  logic                    rd_vld;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // a slot never written since reset reads as empty
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

// ===== rtl/rendezvous_slot_table.sv =====
// channel   ports                                    handshake
// request   opcode, slot_index, requester_id         start & !busy
// result    outcome, partner_id                      done, one cycle, no stall
//
// each request runs as follows: the accept edge reads the slot store, the
// next edge checks the role, writes the slot back and registers the result.
// busy is high for the one cycle between, so no new word enters while one is in
// work; the registered read of the slot store sets it.
// done is high for the cycle right after the busy cycle; no stall possible.
// synchronous reset empties every slot at once through per-slot valid flags.
module rendezvous_slot_table (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] opcode,
  input  logic [4:0] slot_index,
  input  logic [4:0] requester_id,
  output logic       done,
  output logic [1:0] outcome,
  output logic [4:0] partner_id
);
  import rdv_pkg::*;

  rdv_state_t         state, state_next;
  logic               accept;
  logic [4:0]         slot_sel;
  logic               bad_req;
  logic               rd_en;
  rdv_entry_t         rd_data;
  rdv_wr_t            wr;

  logic               req_err;
  rdv_role_t          req_role;
  logic [4:0]         req_hart;
  logic [SLOT_AW-1:0] req_addr;

  logic               res_done;
  logic [1:0]         res_outcome;
  logic [4:0]         res_partner;

  assign accept   = start && !busy;
  assign slot_sel = (opcode == OP_NOTIFY_OWN) ? requester_id : slot_index;
  assign bad_req  = (opcode != OP_WAIT && opcode != OP_NOTIFY && opcode != OP_NOTIFY_OWN)
                 || (int'(requester_id) >= HART_COUNT)
                 || (int'(slot_sel) >= SLOT_COUNT);
  assign rd_en    = accept && !bad_req;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_EXEC;
      ST_EXEC: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = 1'b0;
    case (state)
      ST_IDLE: busy = 1'b0;
      ST_EXEC: busy = 1'b1;
      default: busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_err  <= bad_req;
      req_role <= (opcode == OP_WAIT) ? ROLE_WAITER : ROLE_NOTIFIER;
      req_hart <= requester_id;
      req_addr <= slot_sel[SLOT_AW-1:0];
    end
  end

  rdv_slot_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (slot_sel[SLOT_AW-1:0]),
    .rd_data (rd_data),
    .wr      (wr)
  );

  // role check on the slot just read, and the write back
  always_comb begin
    wr.en       = 1'b0;
    wr.addr     = req_addr;
    wr.data     = '0;
    res_outcome = OUT_ERROR;
    res_partner = '0;
    if (busy && !req_err) begin
      if (rd_data.role == ROLE_EMPTY) begin
        wr.en        = 1'b1;
        wr.data.role = req_role;
        wr.data.hart = req_hart;
        res_outcome  = OUT_PARKED;
      end else if (rd_data.role != req_role) begin
        wr.en       = 1'b1;
        res_outcome = OUT_RELEASED;
        res_partner = rd_data.hart;
      end
    end
  end

  assign res_done = busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res_done;
    end
  end

  always_ff @(posedge clk) begin
    if (res_done) begin
      outcome    <= res_outcome;
      partner_id <= res_partner;
    end
  end

endmodule

// ===== rtl/rdv_checker.sv =====
module rdv_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [1:0] outcome,
  input logic [4:0] partner_id
);
  import rdv_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> done && !busy)
    else $error("busy did not end in one result word");

  a_done_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result word without a request in work");

  a_partner_zero: assert property (@(posedge clk) disable iff (rst)
    done && outcome != OUT_RELEASED |-> partner_id == 5'd0)
    else $error("partner id set on a result that releases no one");

  a_outcome_code: assert property (@(posedge clk) disable iff (rst)
    done |-> outcome == OUT_PARKED || outcome == OUT_RELEASED || outcome == OUT_ERROR)
    else $error("undefined outcome code");

endmodule

bind rendezvous_slot_table rdv_checker u_rdv_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .outcome    (outcome),
  .partner_id (partner_id)
);

// ===== dv/rendezvous_slot_table_tb.sv =====
module rendezvous_slot_table_tb;
  import rdv_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [1:0] outcome;
    logic [4:0] partner;
  } reply_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [1:0] opcode = '0;
  logic [4:0] slot_index = '0;
  logic [4:0] requester_id = '0;
  logic       busy;
  logic       done;
  logic [1:0] outcome;
  logic [4:0] partner_id;

  rdv_role_t  slot_role [SLOT_COUNT];
  logic [4:0] slot_hart [SLOT_COUNT];
  reply_t     pending_replies [$];
  int         fail_count = 0;
  int         words_sent = 0;
  int         cycle_count = 0;
  bit         gaps_on = 1'b1;

  rendezvous_slot_table u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .slot_index   (slot_index),
    .requester_id (requester_id),
    .done         (done),
    .outcome      (outcome),
    .partner_id   (partner_id)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("rendezvous_slot_table_tb failed");
      $finish;
    end
  end

  // one atomic read-modify-write of the addressed slot
  function automatic reply_t resolve_request(logic [1:0] op, logic [4:0] slot,
                                             logic [4:0] hart);
    reply_t    r;
    int        target;
    rdv_role_t mine;
    r.outcome = OUT_ERROR;
    r.partner = '0;
    if (op == OP_UNUSED || int'(hart) >= HART_COUNT) return r;
    target = (op == OP_NOTIFY_OWN) ? int'(hart) : int'(slot);
    if (target >= SLOT_COUNT) return r;
    mine = (op == OP_WAIT) ? ROLE_WAITER : ROLE_NOTIFIER;
    if (slot_role[target] == ROLE_EMPTY) begin
      slot_role[target] = mine;
      slot_hart[target] = hart;
      r.outcome = OUT_PARKED;
    end else if (slot_role[target] != mine) begin
      r.outcome = OUT_RELEASED;
      r.partner = slot_hart[target];
      slot_role[target] = ROLE_EMPTY;
      slot_hart[target] = '0;
    end
    return r;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic issue_word(input logic [1:0] op, input logic [4:0] slot,
                            input logic [4:0] hart);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    opcode       <= op;
    slot_index   <= slot;
    requester_id <= hart;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_replies.push_back(resolve_request(op, slot, hart));
    words_sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_replies
    reply_t want;
    if (!rst && done) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: result with nothing pending: outcome %0d partner %0d",
                 $time, outcome, partner_id);
        fail_count++;
      end else begin
        want = pending_replies.pop_front();
        if (outcome !== want.outcome) begin
          $display("%0t: outcome expected %0d actual %0d", $time, want.outcome, outcome);
          fail_count++;
        end
        if (partner_id !== want.partner) begin
          $display("%0t: partner_id expected %0d actual %0d",
                   $time, want.partner, partner_id);
          fail_count++;
        end
      end
    end
  end

  task automatic apply_reset();
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_role[i] = ROLE_EMPTY;
      slot_hart[i] = '0;
    end
    rst <= 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  endtask

  task automatic test_directed();
    issue_word(OP_WAIT, 5'd0, 5'd5);
    issue_word(OP_WAIT, 5'd0, 5'd6);         // waiter meets waiter
    issue_word(OP_NOTIFY, 5'd0, 5'd7);
    issue_word(OP_NOTIFY, 5'd23, 5'd31);
    issue_word(OP_NOTIFY, 5'd23, 5'd0);      // notifier meets notifier
    issue_word(OP_WAIT, 5'd23, 5'd1);
    issue_word(OP_NOTIFY_OWN, 5'd31, 5'd3);
    issue_word(OP_NOTIFY_OWN, 5'd0, 5'd3);   // same role through own slot
    issue_word(OP_WAIT, 5'd3, 5'd9);
    issue_word(OP_WAIT, 5'd4, 5'd4);
    issue_word(OP_NOTIFY_OWN, 5'd0, 5'd4);
    issue_word(OP_NOTIFY_OWN, 5'd5, 5'd24);  // own slot past the table
    issue_word(OP_NOTIFY_OWN, 5'd0, 5'd31);
    issue_word(OP_UNUSED, 5'd0, 5'd0);
    issue_word(OP_UNUSED, 5'd31, 5'd31);
    issue_word(OP_WAIT, 5'd24, 5'd2);
    issue_word(OP_NOTIFY, 5'd31, 5'd2);
    issue_word(OP_WAIT, 5'd0, 5'd0);
    issue_word(OP_NOTIFY, 5'd0, 5'd31);      // partner id zero on release
    issue_word(OP_NOTIFY, 5'd16, 5'd16);
    issue_word(OP_WAIT, 5'd16, 5'd15);
    issue_word(OP_NOTIFY_OWN, 5'd31, 5'd23);
    issue_word(OP_WAIT, 5'd23, 5'd30);
    wait_drained();
  endtask

  // well-formed park then release on one slot, random harts
  task automatic test_pairs(input int count);
    int         target;
    logic [4:0] hart_a;
    logic [4:0] hart_b;
    int         stop_at;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      target = $urandom_range(0, SLOT_COUNT - 1);
      hart_a = 5'($urandom_range(0, 31));
      hart_b = 5'($urandom_range(0, 31));
      case ($urandom_range(0, 3))
        0: begin
          issue_word(OP_WAIT, 5'(target), hart_a);
          issue_word(OP_NOTIFY, 5'(target), hart_b);
        end
        1: begin
          issue_word(OP_NOTIFY, 5'(target), hart_a);
          issue_word(OP_WAIT, 5'(target), hart_b);
        end
        2: begin
          issue_word(OP_WAIT, 5'(target), hart_a);
          issue_word(OP_NOTIFY_OWN, 5'($urandom_range(0, 31)), 5'(target));
        end
        default: begin
          issue_word(OP_NOTIFY_OWN, 5'($urandom_range(0, 31)), 5'(target));
          issue_word(OP_WAIT, 5'(target), hart_b);
        end
      endcase
    end
  endtask

  // broken requests: unused opcode, slot or own slot past the table
  task automatic test_noise(input int count);
    repeat (count) begin
      case ($urandom_range(0, 2))
        0: issue_word(OP_UNUSED, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
        1: issue_word(2'($urandom_range(0, 1)), 5'($urandom_range(SLOT_COUNT, 31)),
                      5'($urandom_range(0, 31)));
        default: issue_word(OP_NOTIFY_OWN, 5'($urandom_range(0, 31)),
                            5'($urandom_range(SLOT_COUNT, 31)));
      endcase
    end
  endtask

  // random requests, often on a few hot slots so that conflicts pile up
  task automatic test_mixed(input int count);
    logic [1:0] op;
    logic [4:0] slot;
    int         r;
    for (int n = 0; n < count; n++) begin
      if (n % 150 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      if (n == count / 2) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 6) op = OP_UNUSED;
      else op = 2'($urandom_range(0, 2));
      if (r < 40) slot = 5'($urandom_range(0, 3));
      else if (r < 92) slot = 5'($urandom_range(0, SLOT_COUNT - 1));
      else slot = 5'($urandom_range(0, 31));
      if (op == OP_NOTIFY_OWN && r < 50)
        issue_word(op, slot, 5'($urandom_range(0, 3)));
      else
        issue_word(op, slot, 5'($urandom_range(0, 31)));
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    apply_reset();
    test_directed();
    test_pairs(500);
    wait_drained();
    test_noise(100);
    test_mixed(1000);
    wait_drained();
    if (fail_count == 0) begin
      $display("rendezvous_slot_table_tb passed");
    end else begin
      $display("rendezvous_slot_table_tb failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rdv_pkg.sv
rtl/rdv_slot_ram.sv
rtl/rendezvous_slot_table.sv
rtl/rdv_checker.sv
dv/rendezvous_slot_table_tb.sv
